// ===== sv/svq_pkg.sv =====
// svq_pkg: shared types and codes for the service queue with history
// no dependencies; imported by every module of the block
`default_nettype none

package svq_pkg;

  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned TKT_BITS    = 16;

  typedef enum logic [OP_BITS-1:0] {
    OP_REGISTER = 3'd0,
    OP_ENQUEUE  = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_PROMOTE  = 3'd3,
    OP_COMPLETE = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_NOT_REG    = 3'd2,
    ST_DUP        = 3'd3,
    ST_NOT_QUEUED = 3'd4,
    ST_FIRST      = 3'd5,
    ST_FULL       = 3'd6,
    ST_IDS_OUT    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHL,
    WR_SHR,
    WR_FRONT
  } wr_op_e;

  // controller to datapath
  typedef struct packed {
    logic    idle;
    idx_op_e idx_op;
    logic    idx_back;
    wr_op_e  wr_op;
    logic    save;
    logic    commit;
    status_e status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               loaded;
    logic [OP_BITS-1:0] op;
    logic               empty;
    logic               full;
    logic               ids_out;
    logic               none_reg;
    logic               id_bad;
    logic               hit;
    logic               last;
    logic               front;
    logic               out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/svq_cmd_if.sv =====
// svq_cmd_if: command channel, valid/ready with opcode and client id
// depends on svq_pkg for the opcode width
`default_nettype none

interface svq_cmd_if
  import svq_pkg::*;
#(
  parameter int unsigned ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic [OP_BITS-1:0] op;
  logic [ID_BITS-1:0] client_id;

  modport source (output valid, output op, output client_id, input ready);
  modport sink   (input valid, input op, input client_id, output ready);
endinterface

`default_nettype wire

// ===== sv/svq_rsp_if.sv =====
// svq_rsp_if: response channel, valid/ready with status, id, ticket and counts
// depends on svq_pkg for field widths
`default_nettype none

interface svq_rsp_if
  import svq_pkg::*;
#(
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned QLEN_BITS = 5,
  parameter int unsigned HCNT_BITS = 6
);
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]     result_id;
  logic [TKT_BITS-1:0]    ticket;
  logic [QLEN_BITS-1:0]   queue_length;
  logic [HCNT_BITS-1:0]   history_count;

  modport source (output valid, output status, output result_id, output ticket,
                  output queue_length, output history_count, input ready);
  modport sink   (input valid, input status, input result_id, input ticket,
                  input queue_length, input history_count, output ready);
endinterface

`default_nettype wire

// ===== sv/svq_ctrl.sv =====
// svq_ctrl: command sequencer for search, shift and commit of one command
// depends on svq_pkg (dp_cmd_t, dp_stat_t, opcodes, status codes)
`default_nettype none

module svq_ctrl
  import svq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH,
    S_SHL,
    S_SHR_FILL,
    S_SHR,
    S_FRONT,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  status_e enq_tail;

  // enqueue outcome once the id is known to be absent
  always_comb begin
    if (stat_i.id_bad) begin
      enq_tail = ST_NOT_REG;
    end else if (stat_i.full) begin
      enq_tail = ST_FULL;
    end else begin
      enq_tail = ST_OK;
    end
  end

  always_comb begin
    state_d         = state_q;
    res_d           = res_q;
    cmd_o.idle      = 1'b0;
    cmd_o.idx_op    = IDX_HOLD;
    cmd_o.idx_back  = 1'b0;
    cmd_o.wr_op     = WR_NONE;
    cmd_o.save      = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.status    = res_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.idle   = 1'b1;
        cmd_o.idx_op = IDX_ZERO;
        if (stat_i.loaded) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_REGISTER: begin
            if (stat_i.ids_out) begin
              res_d = ST_IDS_OUT;
            end else if (stat_i.full) begin
              res_d = ST_FULL;
            end else begin
              res_d = ST_OK;
            end
          end
          OP_ENQUEUE: begin
            if (stat_i.none_reg) begin
              res_d = ST_NOT_REG;
            end else if (stat_i.empty) begin
              res_d = enq_tail;
            end else begin
              cmd_o.idx_op = IDX_INC;
              state_d      = S_SRCH;
            end
          end
          OP_REMOVE, OP_PROMOTE, OP_COMPLETE: begin
            if (stat_i.empty) begin
              res_d = ST_EMPTY;
            end else begin
              cmd_o.idx_op = IDX_INC;
              state_d      = S_SRCH;
            end
          end
          default: begin
            res_d = ST_OK;
          end
        endcase
      end
      S_SRCH: begin
        cmd_o.idx_op = IDX_INC;
        if (stat_i.hit) begin
          case (stat_i.op)
            OP_ENQUEUE: begin
              res_d   = ST_DUP;
              state_d = S_DONE;
            end
            OP_PROMOTE: begin
              if (stat_i.front) begin
                res_d   = ST_FIRST;
                state_d = S_DONE;
              end else begin
                cmd_o.save     = 1'b1;
                cmd_o.idx_op   = IDX_HOLD;
                cmd_o.idx_back = 1'b1;
                state_d        = S_SHR_FILL;
              end
            end
            default: begin
              if (stat_i.last) begin
                res_d   = ST_OK;
                state_d = S_DONE;
              end else begin
                state_d = S_SHL;
              end
            end
          endcase
        end else if (stat_i.last) begin
          state_d = S_DONE;
          if (stat_i.op == OP_ENQUEUE) begin
            res_d = enq_tail;
          end else begin
            res_d = ST_NOT_QUEUED;
          end
        end
      end
      S_SHL: begin
        cmd_o.wr_op  = WR_SHL;
        cmd_o.idx_op = IDX_INC;
        if (stat_i.last) begin
          res_d   = ST_OK;
          state_d = S_DONE;
        end
      end
      S_SHR_FILL: begin
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_SHR;
      end
      S_SHR: begin
        cmd_o.wr_op = WR_SHR;
        if (stat_i.front) begin
          state_d = S_FRONT;
        end else begin
          cmd_o.idx_op = IDX_DEC;
        end
      end
      S_FRONT: begin
        cmd_o.wr_op = WR_FRONT;
        res_d       = ST_OK;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/svq_datapath.sv =====
// svq_datapath: queue memory, history ring, counters and response register
// depends on svq_pkg, svq_cmd_if and svq_rsp_if
`default_nettype none

module svq_datapath
  import svq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned HISTORY_DEPTH = 32,
  parameter int unsigned ID_BITS       = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svq_cmd_if.sink   cmd_i,
  svq_rsp_if.source rsp_o,
  input  dp_cmd_t   ctl_i,
  output dp_stat_t  stat_o
);

  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QA  = $clog2(QUEUE_DEPTH);
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HA  = $clog2(HISTORY_DEPTH);
  localparam int unsigned NW  = ID_BITS + 1;
  localparam int unsigned EW  = ID_BITS + TKT_BITS;
  localparam logic [CW-1:0]  QD_C     = CW'(QUEUE_DEPTH);
  localparam logic [HCW-1:0] HD_C     = HCW'(HISTORY_DEPTH);
  localparam logic [HA-1:0]  HWR_LAST = HA'(HISTORY_DEPTH - 1);

  logic [EW-1:0]        qmem [QUEUE_DEPTH];
  logic [ID_BITS:0]     hmem [HISTORY_DEPTH];

  logic [OP_BITS-1:0]   op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [CW-1:0]        count_q, count_d;
  logic [NW-1:0]        next_id_q, next_id_d;
  logic [TKT_BITS-1:0]  tkt_q, tkt_d;
  logic [HCW-1:0]       hcount_q, hcount_d;
  logic [HA-1:0]        hwr_q, hwr_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        pidx_q;
  logic [CW-1:0]        pidx_m1, pidx_p1;
  logic [EW-1:0]        rdata_q, saved_q;
  logic [ID_BITS-1:0]   rd_id;

  logic                 out_valid_q;
  logic [STATUS_BITS-1:0] out_status_q;
  logic [ID_BITS-1:0]   out_rid_q, rid_d;
  logic [TKT_BITS-1:0]  out_tkt_q;
  logic [CW-1:0]        out_qlen_q;
  logic [HCW-1:0]       out_hcnt_q;

  logic                 loaded;
  logic                 ok, do_app, do_drop, do_clr;
  logic [ID_BITS-1:0]   app_id;
  logic                 wr_en;
  logic [QA-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  assign cmd_i.ready = ctl_i.idle;
  assign loaded      = cmd_i.valid & cmd_i.ready;

  assign rd_id   = rdata_q[EW-1:TKT_BITS];
  assign pidx_m1 = pidx_q - CW'(1);
  assign pidx_p1 = pidx_q + CW'(1);

  assign stat_o.loaded   = loaded;
  assign stat_o.op       = op_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q >= QD_C);
  assign stat_o.ids_out  = next_id_q[ID_BITS];
  assign stat_o.none_reg = (next_id_q <= NW'(1));
  assign stat_o.id_bad   = (id_q == '0) || ({1'b0, id_q} >= next_id_q);
  assign stat_o.hit      = (rd_id == id_q);
  assign stat_o.last     = ({1'b0, pidx_q} + (CW + 1)'(1)) >= {1'b0, count_q};
  assign stat_o.front    = (pidx_q == '0);
  assign stat_o.out_free = !out_valid_q || rsp_o.ready;

  // commit decode
  assign ok      = (ctl_i.status == ST_OK);
  assign do_app  = ctl_i.commit && ok && (op_q == OP_REGISTER || op_q == OP_ENQUEUE);
  assign do_drop = ctl_i.commit && ok && (op_q == OP_REMOVE || op_q == OP_COMPLETE);
  assign do_clr  = ctl_i.commit && (op_q == OP_CLEAR);
  assign app_id  = (op_q == OP_REGISTER) ? next_id_q[ID_BITS-1:0] : id_q;

  // walk index
  always_comb begin
    idx_d = idx_q;
    if (ctl_i.idx_back) begin
      idx_d = pidx_m1;
    end else begin
      case (ctl_i.idx_op)
        IDX_ZERO: idx_d = '0;
        IDX_INC:  idx_d = idx_q + CW'(1);
        IDX_DEC:  idx_d = idx_q - CW'(1);
        default:  idx_d = idx_q;
      endcase
    end
  end

  // queue memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[QA-1:0];
    wr_data = {app_id, tkt_q};
    case (ctl_i.wr_op)
      WR_SHL: begin
        wr_en   = 1'b1;
        wr_addr = pidx_m1[QA-1:0];
        wr_data = rdata_q;
      end
      WR_SHR: begin
        wr_en   = 1'b1;
        wr_addr = pidx_p1[QA-1:0];
        wr_data = rdata_q;
      end
      WR_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = saved_q;
      end
      default: begin
        wr_en = do_app;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      qmem[wr_addr] <= wr_data;
    end
    rdata_q <= qmem[idx_q[QA-1:0]];
    if (ctl_i.save) begin
      saved_q <= rdata_q;
    end
  end

  // history ring: the oldest entry is overwritten once the ring is full
  always_ff @(posedge clk_i) begin
    if (do_drop) begin
      hmem[hwr_q] <= {id_q, (op_q == OP_COMPLETE)};
    end
  end

  always_comb begin
    count_d   = count_q;
    next_id_d = next_id_q;
    tkt_d     = tkt_q;
    hcount_d  = hcount_q;
    hwr_d     = hwr_q;
    if (do_app) begin
      count_d = count_q + CW'(1);
      tkt_d   = tkt_q + TKT_BITS'(1);
      if (op_q == OP_REGISTER) begin
        next_id_d = next_id_q + NW'(1);
      end
    end
    if (do_drop) begin
      count_d = count_q - CW'(1);
      hwr_d   = (hwr_q == HWR_LAST) ? '0 : hwr_q + HA'(1);
      if (hcount_q != HD_C) begin
        hcount_d = hcount_q + HCW'(1);
      end
    end
    if (do_clr) begin
      hcount_d = '0;
    end
  end

  always_comb begin
    case (op_q)
      OP_REGISTER: rid_d = ok ? next_id_q[ID_BITS-1:0] : '0;
      OP_ENQUEUE:  rid_d = id_q;
      OP_REMOVE, OP_PROMOTE, OP_COMPLETE: begin
        rid_d = (ctl_i.status == ST_EMPTY) ? '0 : id_q;
      end
      default:     rid_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      next_id_q   <= NW'(1);
      tkt_q       <= TKT_BITS'(1);
      hcount_q    <= '0;
      hwr_q       <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      next_id_q <= next_id_d;
      tkt_q     <= tkt_d;
      hcount_q  <= hcount_d;
      hwr_q     <= hwr_d;
      idx_q     <= idx_d;
      pidx_q    <= idx_q;
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (loaded) begin
      op_q <= cmd_i.op;
      id_q <= cmd_i.client_id;
    end
    if (ctl_i.commit) begin
      out_status_q <= ctl_i.status;
      out_rid_q    <= rid_d;
      out_tkt_q    <= do_app ? tkt_q : '0;
      out_qlen_q   <= count_d;
      out_hcnt_q   <= hcount_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.result_id     = out_rid_q;
  assign rsp_o.ticket        = out_tkt_q;
  assign rsp_o.queue_length  = out_qlen_q;
  assign rsp_o.history_count = out_hcnt_q;

endmodule

`default_nettype wire

// ===== sv/service_queue_with_history.sv =====
// Register, clear and unused codes are settled at decode; keyed commands on a
// non-empty queue also search for the id, remove and complete shift the entries
// behind it forward, and promote shifts those ahead of it back and writes it first.
// One command is worked at a time, walking the dual-port queue memory one
// entry per cycle; the next command is taken while the result waits.
// Reset (async, active low): queue and history empty, next id 1, ticket 1.
`default_nettype none

module service_queue_with_history
  import svq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned HISTORY_DEPTH = 32,
  parameter int unsigned ID_BITS       = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svq_cmd_if.sink   cmd_i,
  svq_rsp_if.source rsp_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  svq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  svq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ID_BITS       (ID_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .rsp_o  (rsp_o),
    .ctl_i  (dp_cmd),
    .stat_o (dp_stat)
  );

endmodule

`default_nettype wire

// ===== sv/svq_checker.sv =====
// svq_checker: port-level checks on the response channel of the block
// depends on svq_pkg; bound to service_queue_with_history
`default_nettype none

module svq_checker
  import svq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned HISTORY_DEPTH = 32,
  parameter int unsigned ID_BITS       = 8
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   rsp_valid_i,
  input logic                                   rsp_ready_i,
  input logic [STATUS_BITS-1:0]                 status_i,
  input logic [ID_BITS-1:0]                     result_id_i,
  input logic [$clog2(QUEUE_DEPTH + 1)-1:0]     queue_length_i,
  input logic [$clog2(HISTORY_DEPTH + 1)-1:0]   history_count_i
);

  localparam int unsigned QLW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HLW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [QLW-1:0] QD_C = QLW'(QUEUE_DEPTH);
  localparam logic [HLW-1:0] HD_C = HLW'(HISTORY_DEPTH);

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before transaction completed");

  a_qlen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> queue_length_i <= QD_C)
    else $error("queue length beyond depth");

  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> history_count_i <= HD_C)
    else $error("history count beyond depth");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_FULL |-> queue_length_i == QD_C)
    else $error("queue full reported with free entries");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_EMPTY |-> queue_length_i == '0 && result_id_i == '0)
    else $error("queue empty reported with entries or an id");

endmodule

bind service_queue_with_history svq_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .HISTORY_DEPTH (HISTORY_DEPTH),
  .ID_BITS       (ID_BITS)
) u_svq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .result_id_i     (rsp_o.result_id),
  .queue_length_i  (rsp_o.queue_length),
  .history_count_i (rsp_o.history_count)
);

`default_nettype wire

// ===== verif/service_queue_with_history_test.sv =====
// service_queue_with_history_test: self-checking bench that drives commands and predicts
// every response from a behavioral copy of the queue, ticket and history state
// depends on svq_pkg, svq_cmd_if, svq_rsp_if and service_queue_with_history
`default_nettype none

module service_queue_with_history_test;
  import svq_pkg::*;

  localparam int Q_DEPTH        = 16;
  localparam int H_DEPTH        = 32;
  localparam int ID_LIMIT       = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    status_e     status;
    logic [7:0]  result_id;
    logic [15:0] ticket;
    logic [4:0]  queue_length;
    logic [5:0]  history_count;
  } service_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  svq_cmd_if #(.ID_BITS(8)) cmd_if ();
  svq_rsp_if #(.ID_BITS(8), .QLEN_BITS(5), .HCNT_BITS(6)) rsp_if ();

  service_queue_with_history dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the block state
  logic [7:0]  q_id [Q_DEPTH];
  int          q_cnt    = 0;
  int          next_id  = 1;
  logic [15:0] next_tkt = 16'd1;
  int          hist_top = 0;

  service_result_t pending_results[$];
  int  errors       = 0;
  int  burst_left   = 0;
  int  stuck_cycles = 0;

  function automatic int queue_pos(logic [7:0] id);
    for (int i = 0; i < q_cnt; i++) begin
      if (q_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [15:0] append_entry(logic [7:0] id);
    logic [15:0] t;
    t = next_tkt;
    q_id[q_cnt] = id;
    q_cnt++;
    next_tkt = next_tkt + 16'd1;
    return t;
  endfunction

  function automatic service_result_t service_step(logic [OP_BITS-1:0] op, logic [7:0] id);
    service_result_t r;
    int pos;
    r.status    = ST_OK;
    r.result_id = '0;
    r.ticket    = '0;
    case (op)
      OP_REGISTER: begin
        if (next_id >= ID_LIMIT) r.status = ST_IDS_OUT;
        else if (q_cnt >= Q_DEPTH) r.status = ST_FULL;
        else begin
          r.result_id = 8'(next_id);
          next_id++;
          r.ticket = append_entry(r.result_id);
        end
      end
      OP_ENQUEUE: begin
        r.result_id = id;
        if (next_id <= 1) r.status = ST_NOT_REG;
        else if (queue_pos(id) >= 0) r.status = ST_DUP;
        else if (id < 1 || id >= next_id) r.status = ST_NOT_REG;
        else if (q_cnt >= Q_DEPTH) r.status = ST_FULL;
        else r.ticket = append_entry(id);
      end
      OP_REMOVE, OP_COMPLETE: begin
        if (q_cnt == 0) r.status = ST_EMPTY;
        else begin
          r.result_id = id;
          pos = queue_pos(id);
          if (pos < 0) r.status = ST_NOT_QUEUED;
          else begin
            for (int i = pos; i + 1 < q_cnt; i++) q_id[i] = q_id[i+1];
            q_cnt--;
            // oldest entry falls out of a full history
            if (hist_top >= H_DEPTH) hist_top = H_DEPTH - 1;
            hist_top++;
          end
        end
      end
      OP_PROMOTE: begin
        if (q_cnt == 0) r.status = ST_EMPTY;
        else begin
          r.result_id = id;
          pos = queue_pos(id);
          if (q_id[0] == id) r.status = ST_FIRST;
          else if (pos < 0) r.status = ST_NOT_QUEUED;
          else begin
            for (int i = pos; i > 0; i--) q_id[i] = q_id[i-1];
            q_id[0] = id;
          end
        end
      end
      OP_CLEAR: hist_top = 0;
      default: ;
    endcase
    r.queue_length  = 5'(q_cnt);
    r.history_count = 6'(hist_top);
    return r;
  endfunction

  function automatic logic [7:0] queued_id();
    return q_id[$urandom_range(q_cnt - 1)];
  endfunction

  function automatic logic [7:0] registered_id();
    return 8'($urandom_range(next_id - 1, 1));
  endfunction

  // sender: bursts of random length with random gaps
  task automatic pace();
    if (burst_left > 0) burst_left--;
    else begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
    end
  endtask

  task automatic issue_cmd(logic [OP_BITS-1:0] op, logic [7:0] id);
    cmd_if.valid     <= 1'b1;
    cmd_if.op        <= op;
    cmd_if.client_id <= id;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_results.push_back(service_step(op, id));
    pace();
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR %s", msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // response checker
  always @(posedge clk_i) begin
    service_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending, status %0d id %0d",
                                  rsp_if.status, rsp_if.result_id));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(rsp_if.status), 16'(want.status));
        check_field("result_id", 16'(rsp_if.result_id), 16'(want.result_id));
        check_field("ticket", rsp_if.ticket, want.ticket);
        check_field("queue_length", 16'(rsp_if.queue_length), 16'(want.queue_length));
        check_field("history_count", 16'(rsp_if.history_count), 16'(want.history_count));
      end
    end
  end

  // receiver stalls on a rotating pattern, reloaded with a random pattern or all ones
  initial begin
    logic [15:0] stall_pat;
    int cyc;
    rsp_if.ready = 1'b0;
    stall_pat = 16'hFFFF;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (cyc % 64 == 0)
        stall_pat = ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      rsp_if.ready <= stall_pat[0];
      cyc++;
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_basic();
    issue_cmd(OP_ENQUEUE, 8'd0);
    issue_cmd(OP_ENQUEUE, 8'd255);
    issue_cmd(OP_REMOVE, 8'd3);
    issue_cmd(OP_PROMOTE, 8'd3);
    issue_cmd(OP_COMPLETE, 8'd3);
    issue_cmd(OP_CLEAR, 8'd0);
    issue_cmd(OP_SPARE_LO, 8'hAA);
    issue_cmd(OP_SPARE_HI, 8'h55);
    repeat (4) issue_cmd(OP_REGISTER, 8'hFF);
    issue_cmd(OP_ENQUEUE, 8'd2);
    issue_cmd(OP_ENQUEUE, 8'd9);
    issue_cmd(OP_ENQUEUE, 8'd0);
    issue_cmd(OP_PROMOTE, 8'd1);
    issue_cmd(OP_PROMOTE, 8'd3);
    issue_cmd(OP_REMOVE, 8'd9);
    issue_cmd(OP_REMOVE, 8'd2);
    issue_cmd(OP_COMPLETE, 8'd4);
    issue_cmd(OP_ENQUEUE, 8'd2);
    issue_cmd(OP_COMPLETE, 8'd255);
    issue_cmd(OP_CLEAR, 8'd0);
  endtask

  task automatic test_queue_full();
    logic [7:0] gone;
    while (q_cnt < Q_DEPTH) issue_cmd(OP_REGISTER, 8'($urandom_range(255)));
    issue_cmd(OP_REGISTER, 8'd0);
    issue_cmd(OP_ENQUEUE, q_id[Q_DEPTH-1]);
    issue_cmd(OP_ENQUEUE, 8'd254);
    issue_cmd(OP_PROMOTE, q_id[Q_DEPTH-1]);
    gone = q_id[Q_DEPTH-1];
    issue_cmd(OP_COMPLETE, gone);
    issue_cmd(OP_REGISTER, 8'd0);
    issue_cmd(OP_ENQUEUE, gone);
    issue_cmd(OP_REMOVE, q_id[0]);
    issue_cmd(OP_ENQUEUE, gone);
  endtask

  task automatic test_history_overflow();
    int pushes;
    pushes = 0;
    issue_cmd(OP_CLEAR, 8'd0);
    while (pushes < H_DEPTH + 4) begin
      if (q_cnt < 2) issue_cmd(OP_REGISTER, 8'($urandom_range(255)));
      else begin
        issue_cmd(pushes[0] ? OP_COMPLETE : OP_REMOVE, queued_id());
        pushes++;
      end
    end
    issue_cmd(OP_CLEAR, 8'd0);
  endtask

  task automatic run_random(int n);
    int k;
    logic [7:0] id;
    logic [OP_BITS-1:0] op;
    repeat (n) begin
      k  = $urandom_range(99);
      id = 8'($urandom_range(255));
      if (k < 14) op = OP_REGISTER;
      else if (k < 32) begin
        op = OP_ENQUEUE;
        if (next_id > 1 && $urandom_range(9) < 6) id = registered_id();
        else if (q_cnt > 0 && $urandom_range(1) == 1) id = queued_id();
      end else if (k < 80) begin
        op = (k < 50) ? OP_REMOVE : (k < 62) ? OP_PROMOTE : OP_COMPLETE;
        if (q_cnt > 0 && $urandom_range(3) != 0) id = queued_id();
      end else if (k < 85) op = OP_CLEAR;
      else if (k < 89) op = ($urandom_range(1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
      else op = OP_BITS'($urandom_range(7));
      issue_cmd(op, id);
    end
  endtask

  task automatic test_ids_exhausted();
    while (next_id < ID_LIMIT) begin
      if (q_cnt >= Q_DEPTH - 1) issue_cmd(OP_COMPLETE, queued_id());
      else issue_cmd(OP_REGISTER, 8'($urandom_range(255)));
    end
    issue_cmd(OP_REGISTER, 8'd0);
    issue_cmd(OP_ENQUEUE, 8'd255);
    issue_cmd(OP_ENQUEUE, 8'd0);
    while (q_cnt < Q_DEPTH) issue_cmd(OP_ENQUEUE, registered_id());
    issue_cmd(OP_REGISTER, 8'd0);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.op        = '0;
    cmd_if.client_id = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic();
    test_queue_full();
    test_history_overflow();
    run_random(350);
    wait_drained();
    test_ids_exhausted();
    run_random(300);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
